// ----- rtl/core/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, widths and character codes for the signed integer to
// decimal ascii converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAG_BITS   = VALUE_BITS;
   localparam longint unsigned Radix = 64'd10;

   // number of decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
   function automatic int digit_count(input int bits);
      longint unsigned v;
      int              n;
      v = 64'd1 << (bits - 1);
      n = 0;
      while (v != 64'd0) begin
         n = n + 1;
         v = v / Radix;
      end
      return n;
   endfunction

   localparam int DIGITS         = digit_count(VALUE_BITS);
   localparam int BCD_BITS       = 4 * DIGITS;
   localparam int DIGIT_IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CNT_BITS       = $clog2(MAG_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] DIGIT_BASE = 8'd48;
   localparam logic [7:0] MINUS_CODE = 8'd45;

   // classified item: sign and magnitude
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } sitda_item_type;

   // queue status toward the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } sitda_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_SIGN,
      ST_DIGIT
   } sitda_state_type;

endpackage

// ----- rtl/core/sitda_front.sv -----
// ----------------------------------------------------------------------------
// sitda_front
// Accepts a value, splits it into sign and magnitude and pushes it into
// the queue.
// ----------------------------------------------------------------------------
module sitda_front (
   input  logic                               start,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   input  sitda_pkg::sitda_qstat_type         qstat,
   output logic                               busy,
   output logic                               push,
   output sitda_pkg::sitda_item_type          push_item
);
   import sitda_pkg::*;

   logic [MAG_BITS-1:0] raw;

   assign raw  = MAG_BITS'(unsigned'(req_value));
   assign busy = qstat.full;
   assign push = start & ~qstat.full;

   // most negative value wraps to 2^(n-1), which fits unsigned
   always_comb begin
      push_item.neg = raw[MAG_BITS-1];
      push_item.mag = raw[MAG_BITS-1] ? (~raw + MAG_BITS'(1)) : raw;
   end

endmodule

// ----- rtl/core/sitda_fifo.sv -----
// ----------------------------------------------------------------------------
// sitda_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module sitda_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sitda_pkg::sitda_item_type push_item,
   input  logic                      pop,
   output sitda_pkg::sitda_item_type head_item,
   output sitda_pkg::sitda_qstat_type qstat
);
   import sitda_pkg::*;

   sitda_item_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_BITS'(1);
   endfunction

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/sitda_back.sv -----
// ----------------------------------------------------------------------------
// sitda_back
// Converts a magnitude to bcd by shift and add-3, one bit per cycle, then
// sends the sign and the significant digits one character per cycle.
// ----------------------------------------------------------------------------
module sitda_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sitda_pkg::sitda_qstat_type qstat,
   input  sitda_pkg::sitda_item_type  head_item,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_ascii_code,
   output logic                       rsp_last_char
);
   import sitda_pkg::*;

   sitda_state_type           state_ff, state_in;
   logic [MAG_BITS-1:0]       mag_ff, mag_in;
   logic [BCD_BITS-1:0]       bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]       bcd_adj;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic [DIGIT_IDX_BITS-1:0] lead;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_code_ff, rsp_code_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [3:0]                cur_digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ?
                             (bcd_ff[i*4 +: 4] + 4'd3) : bcd_ff[i*4 +: 4];
      end
   end

   // highest nonzero digit, zero when the value is zero
   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead = DIGIT_IDX_BITS'(i);
         end
      end
   end

   assign cur_digit = bcd_ff[idx_ff*4 +: 4];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               mag_in   = head_item.mag;
               neg_in   = head_item.neg;
               bcd_in   = '0;
               cnt_in   = CNT_BITS'(MAG_BITS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[MAG_BITS-1]};
            mag_in = {mag_ff[MAG_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = ST_LEAD;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_LEAD: begin
            idx_in   = lead;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = MINUS_CODE;
            state_in     = ST_DIGIT;
         end
         ST_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = DIGIT_BASE + {4'd0, cur_digit};
            rsp_last_in  = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - DIGIT_IDX_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_code = rsp_code_ff;
   assign rsp_last_char  = rsp_last_ff;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ascii text, most significant character first.
//
//   channel   ports                                   beat
//   input     start, busy, req_value                  start & !busy
//   result    rsp_valid, rsp_ascii_code, rsp_last_char one cycle per strobe
//
// An item passes in the back through the bit-serial bcd conversion loop
// and a leading-digit step, then goes out at one character per cycle
// (up to 11 characters).
// The front queues up to two items while the back works, then raises busy.
// Reset clears the queue, the sequencer and the result strobe.
// The receiver takes every result, so the back never stalls.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   output logic                                    rsp_valid,
   output logic [7:0]                              rsp_ascii_code,
   output logic                                    rsp_last_char
);
   import sitda_pkg::*;

   sitda_qstat_type qstat;
   sitda_item_type  push_item;
   sitda_item_type  head_item;
   logic            push;
   logic            pop;

   sitda_front u_front (
      .start     (start),
      .req_value (req_value),
      .qstat     (qstat),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   sitda_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   sitda_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_code (rsp_ascii_code),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

// ----- rtl/core/sitda_checker.sv -----
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
module sitda_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   input logic                                    rsp_valid,
   input logic [7:0]                              rsp_ascii_code,
   input logic                                    rsp_last_char
);
   import sitda_pkg::*;

   logic is_digit;
   logic unused_in;

   assign is_digit  = (rsp_ascii_code >= DIGIT_BASE) &&
                      (rsp_ascii_code <= DIGIT_BASE + 8'd9);
   assign unused_in = start ^ (^req_value);

   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_digit || (rsp_ascii_code == MINUS_CODE)))
      else $error("illegal character code");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ascii_code == MINUS_CODE) |-> !rsp_last_char)
      else $error("minus sign flagged as last");

   a_sign_then_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ascii_code == MINUS_CODE) |=> (rsp_valid && is_digit))
      else $error("minus sign not followed by a digit");

   a_text_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |=> rsp_valid)
      else $error("gap inside one number's text");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy && (unused_in || !unused_in)))
      else $error("strobe or busy set after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the signed integer to decimal ascii converter. A table of directed
// values (zero, single digits, both extremes, powers of ten, bit patterns)
// runs first, then random values in phases with different sender idle
// rates. Each accepted value is expanded into its expected characters, and
// every result strobe is compared with the oldest expected character.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sitda_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int PHASE_ITEMS   = 34;
   localparam int MAX_REPORTS   = 10;
   localparam int NUM_ROWS      = 20;
   localparam int NUM_PHASES    = 3;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_beat_type;

   // empty text means the predictor supplies the expected characters
   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      string                        text;
   } stim_row_type;

   stim_row_type stim_table [NUM_ROWS] = '{
      '{32'sd0,           "0"},
      '{32'sd1,           "1"},
      '{-32'sd1,          "-1"},
      '{32'sd9,           "9"},
      '{32'sd10,          "10"},
      '{-32'sd10,         "-10"},
      '{32'sh7fff_ffff,   "2147483647"},
      '{32'sh8000_0000,   "-2147483648"},
      '{32'sh8000_0001,   "-2147483647"},
      '{32'sd1000000000,  "1000000000"},
      '{-32'sd1000000000, "-1000000000"},
      '{32'sd999999999,   ""},
      '{-32'sd999999999,  ""},
      '{32'sh5555_5555,   ""},
      '{32'shaaaa_aaaa,   ""},
      '{32'sd100,         ""},
      '{32'sd99,          ""},
      '{32'sd1234567890,  ""},
      '{-32'sd987654321,  ""},
      '{32'sh7fff_fffe,   ""}
   };

   int phase_idle_pct [NUM_PHASES] = '{0, 78, 18};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         rsp_valid;
   logic [7:0]                   rsp_ascii_code;
   logic                         rsp_last_char;

   char_beat_type expected_chars [$];
   string         typed_text [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;

   signed_int_to_decimal_ascii u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_code (rsp_ascii_code),
      .rsp_last_char  (rsp_last_char)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   function automatic void push_typed_text(input string s);
      char_beat_type beat;
      for (int i = 0; i < s.len(); i++) begin
         beat.code = s[i];
         beat.last = (i == s.len() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   // sign first, then digits most significant first; magnitude one bit wider
   function automatic void push_decimal_text(input logic signed [VALUE_BITS-1:0] v);
      logic             negative;
      logic [VALUE_BITS:0] mag;
      logic [7:0]       digits [$];
      char_beat_type    beat;
      negative = v[VALUE_BITS-1];
      mag = negative ? -{v[VALUE_BITS-1], v} : {1'b0, v};
      do begin
         digits.push_front(DIGIT_BASE + 8'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      if (negative) begin
         beat.code = MINUS_CODE;
         beat.last = 1'b0;
         expected_chars.push_back(beat);
      end
      for (int i = 0; i < digits.size(); i++) begin
         beat.code = digits[i];
         beat.last = (i == digits.size() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      int                  pick;
      longint unsigned     span;
      logic [VALUE_BITS-1:0] r;
      pick = $urandom_range(9);
      if (pick < 4) begin
         r = VALUE_BITS'($urandom);
      end else if (pick < 8) begin
         // a random digit count, so short and long texts both show up
         span = 1;
         repeat ($urandom_range(1, 10)) span = span * 10;
         r = VALUE_BITS'($urandom % span);
         if ($urandom_range(1)) r = -r;
      end else begin
         case ($urandom_range(3))
            0: r = {1'b1, {(VALUE_BITS-1){1'b0}}} + VALUE_BITS'($urandom_range(2));
            1: r = {1'b0, {(VALUE_BITS-1){1'b1}}} - VALUE_BITS'($urandom_range(2));
            2: r = VALUE_BITS'($urandom_range(2));
            default: r = -VALUE_BITS'($urandom_range(1, 3));
         endcase
      end
      return r;
   endfunction

   // sender idles first, then holds the beat until busy is low at an edge
   task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input string text,
                             input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      typed_text.push_back(text);
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0 || typed_text.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : monitor
      string         text;
      char_beat_type exp_beat;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL signed_int_to_decimal_ascii");
         $finish;
      end else if (!reset) begin
         if (start && !busy) begin
            text = (typed_text.size() != 0) ? typed_text.pop_front() : "";
            if (text.len() != 0) push_typed_text(text);
            else push_decimal_text(req_value);
         end
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               note_mismatch($sformatf("unexpected char %0d last %0b",
                                       rsp_ascii_code, rsp_last_char));
            end else begin
               exp_beat = expected_chars.pop_front();
               if (rsp_ascii_code !== exp_beat.code || rsp_last_char !== exp_beat.last) begin
                  note_mismatch($sformatf("expected char %0d last %0b, got char %0d last %0b",
                                          exp_beat.code, exp_beat.last,
                                          rsp_ascii_code, rsp_last_char));
               end
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) send_value(stim_table[i].value, stim_table[i].text, 0);
      wait_all_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_value(random_value(), "", phase_idle_pct[p]);
            // now and then let the pipeline run dry before the next beat
            if ($urandom_range(19) == 0) wait_all_results();
         end
         wait_all_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("PASS signed_int_to_decimal_ascii");
      end else begin
         $display("FAIL signed_int_to_decimal_ascii");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sitda_pkg.sv
rtl/core/sitda_front.sv
rtl/core/sitda_fifo.sv
rtl/core/sitda_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sitda_checker.sv
tb/testbench.sv
